/* sv/audio_peak_meter_with_hold_unit_defines.svh */
// ---------------------------------------------------------------------------
// audio peak meter assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef AUDIO_PEAK_METER_WITH_HOLD_UNIT_DEFINES_SVH
`define AUDIO_PEAK_METER_WITH_HOLD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define APMH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("audio peak meter check failed");
`define APMH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("audio peak meter check failed");
`else
`define APMH_ASSERT_IMP(lbl, ante, cons)
`define APMH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/apmh_pkg.sv */
// ---------------------------------------------------------------------------
// apmh_pkg
// shared widths, codes and types of the audio peak meter
// ---------------------------------------------------------------------------
`default_nettype none

package apmh_pkg;

    localparam int OP_W       = 2;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 26;
    localparam int CNT_W      = 4;
    localparam int LEVEL_W    = 25;
    localparam int DECAY_W    = 16;
    localparam int AGE_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_BLOCK_END = 2'd1,
        OP_READ      = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_THRESHOLD = 2'd0,
        CFG_DECAY_PER_READ = 2'd1,
        CFG_HOLD_READS     = 2'd2,
        CFG_STALE_READS    = 2'd3
    } t_cfg_idx;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 25'd16777216;
    localparam logic [AGE_W-1:0]   AGE_MAX    = 10'd1023;

    localparam logic [LEVEL_W-1:0] CLIP_THRESHOLD_RST = 25'd1048576;
    localparam logic [DECAY_W-1:0] DECAY_PER_READ_RST = 16'd60000;
    localparam logic [AGE_W-1:0]   HOLD_READS_RST     = 10'd30;
    localparam logic [AGE_W-1:0]   STALE_READS_RST    = 10'd15;

    typedef struct packed {
        logic               reading_valid;
        logic [CH_W-1:0]    out_channel;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] hold_level;
        logic               clipped;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] hold;
        logic [AGE_W-1:0]   age;
    } t_chan_state;

endpackage

`default_nettype wire

/* sv/apmh_ifs.sv */
// ---------------------------------------------------------------------------
// apmh interfaces
// input item, result item and configuration write channels
// ---------------------------------------------------------------------------
`default_nettype none

interface apmh_in_if;
    import apmh_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]           channel_count;
    logic                       source_running;

    modport source(output valid, op, channel, sample, channel_count, source_running,
                   input ready);
    modport sink(input valid, op, channel, sample, channel_count, source_running,
                 output ready);
endinterface

interface apmh_out_if;
    import apmh_pkg::*;
    logic               valid;
    logic               ready;
    logic               reading_valid;
    logic [CH_W-1:0]    out_channel;
    logic [LEVEL_W-1:0] peak_level;
    logic [LEVEL_W-1:0] hold_level;
    logic               clipped;
    logic               last;

    modport source(output valid, reading_valid, out_channel, peak_level, hold_level,
                   clipped, last, input ready);
    modport sink(input valid, reading_valid, out_channel, peak_level, hold_level,
                 clipped, last, output ready);
endinterface

interface apmh_cfg_if;
    import apmh_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/audio_peak_meter_with_hold_unit.sv */
// ---------------------------------------------------------------------------
// audio_peak_meter_with_hold_unit
// per-channel peak meter with decay, peak hold, stale timeout and clip flag
// ---------------------------------------------------------------------------
// usage
//   i_in carries samples, block ends and meter reads; o_out carries results;
//   i_cfg writes the four registers and is always ready.
//   samples are taken one per cycle while no read is in progress; the
//   window peak is a memory with one read and one write port, with a
//   read-modify-write stage and forwarding between close samples.
//   a block end or a read waits while a sample is in the sample stage.
//   a read is decided in idle, then each shown channel passes S_READ,
//   which reads the channel state memory, and S_CALC, which updates it
//   and loads the result; an invalid read passes S_INV, which loads the
//   no-reading result. S_CALC and S_INV wait while the output stalls.
//   reads block the input channel until their last result is loaded.
//   a stalled receiver holds the output register; samples and block ends
//   are still taken while it stalls outside a read; a read walk waits on it.
//   reset (synchronous, active low) clears all state at once through
//   per-entry valid bits; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "audio_peak_meter_with_hold_unit_defines.svh"

module audio_peak_meter_with_hold_unit #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    apmh_cfg_if.sink     i_cfg,
    apmh_in_if.sink      i_in,
    apmh_out_if.source   o_out
);
    import apmh_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NW = $clog2(MAX_CHANNELS + 1);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_CHANNELS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_INV  = 4'b1000
    } t_state;

    function automatic logic [LEVEL_W-1:0] f_decay(input logic [LEVEL_W-1:0] x,
                                                   input logic [DECAY_W-1:0] d);
        logic [LEVEL_W+DECAY_W-1:0] p;
        p = x * d;
        return p[LEVEL_W+DECAY_W-1:DECAY_W];
    endfunction

    // configuration
    logic [LEVEL_W-1:0] r_clip_thr;
    logic [DECAY_W-1:0] r_decay;
    logic [AGE_W-1:0]   r_hold_reads;
    logic [AGE_W-1:0]   r_stale_reads;

    // memories and valid bits
    logic [LEVEL_W-1:0] wp_mem [MAX_CHANNELS];
    t_chan_state        st_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_wp_vld;
    logic [MAX_CHANNELS-1:0] r_st_vld;
    logic [LEVEL_W-1:0] r_wp_rd;
    t_chan_state        r_st_rd;
    logic [AW-1:0]      wp_raddr;

    // control state
    t_state             r_state;
    logic               r_block_clip;
    logic               r_clip_latched;
    logic               r_fresh_blk;
    logic [NW-1:0]      r_reported;
    logic [NW-1:0]      r_shown;
    logic               r_live;
    logic [AGE_W-1:0]   r_stale_age;
    logic [AW-1:0]      r_ch;
    logic               r_rd_fresh;
    logic               r_restart;

    // sample stage and forwarding
    logic               r_s1_v;
    logic [AW-1:0]      r_s1_ch;
    logic [LEVEL_W-1:0] r_s1_mag;
    logic               r_fw_v;
    logic [AW-1:0]      r_fw_ch;
    logic [LEVEL_W-1:0] r_fw_val;

    // output register
    logic               r_out_v;
    t_result            r_out;

    logic               in_fire;
    logic               cfg_fire;
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] mag_raw;
    logic [LEVEL_W-1:0] mag;
    logic               ch_ok;
    logic [LEVEL_W-1:0] wp_base;
    logic [LEVEL_W-1:0] wp_new;
    logic [NW-1:0]      cnt_sat;
    logic [AGE_W-1:0]   stale_inc;
    logic               rd_invalid;
    logic               rd_restart;
    logic               slot_free;
    logic               out_load;
    logic               ch_last;
    logic [LEVEL_W-1:0] measured;
    t_chan_state        st_cur;
    t_chan_state        st_new;
    logic [AGE_W-1:0]   age_inc;
    logic [LEVEL_W-1:0] lv_dec;
    logic [LEVEL_W-1:0] hd_dec;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    assign i_in.ready = (r_state == S_IDLE) && ((i_in.op == OP_SAMPLE) || !r_s1_v);
    assign in_fire    = i_in.valid && i_in.ready;

    // sample magnitude, clamped at full scale
    always_comb begin
        raw     = i_in.sample;
        mag_raw = raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw) : raw;
        mag     = (mag_raw > {1'b0, FULL_SCALE}) ? FULL_SCALE : mag_raw[LEVEL_W-1:0];
        ch_ok   = {29'd0, i_in.channel} < 32'(MAX_CHANNELS);
    end

    // window peak read-modify-write with forwarding of the previous write
    always_comb begin
        if (r_fw_v && (r_fw_ch == r_s1_ch)) begin
            wp_base = r_fw_val;
        end else if (r_wp_vld[r_s1_ch]) begin
            wp_base = r_wp_rd;
        end else begin
            wp_base = '0;
        end
        wp_new = (r_s1_mag > wp_base) ? r_s1_mag : wp_base;
    end

    always_comb begin
        cnt_sat = (int'(i_in.channel_count) > MAX_CHANNELS) ? N_MAX
                                                            : NW'(i_in.channel_count);
        stale_inc  = (r_stale_age != AGE_MAX) ? (r_stale_age + AGE_W'(1)) : r_stale_age;
        rd_invalid = !i_in.source_running
                     || (!r_fresh_blk && (!r_live || (stale_inc > r_stale_reads)))
                     || (r_reported == '0);
        rd_restart = !r_live || (r_reported != r_shown);
    end

    // per channel update
    always_comb begin
        measured = (r_rd_fresh && r_wp_vld[r_ch]) ? r_wp_rd : '0;
        st_cur   = r_st_vld[r_ch] ? r_st_rd : '0;
        age_inc  = (!r_restart && (st_cur.age != AGE_MAX)) ? (st_cur.age + AGE_W'(1))
                                                           : st_cur.age;
        lv_dec   = r_restart ? st_cur.level : f_decay(st_cur.level, r_decay);
        hd_dec   = r_restart ? st_cur.hold : f_decay(st_cur.hold, r_decay);
        st_new.level = (measured > lv_dec) ? measured : lv_dec;
        if (measured >= st_cur.hold) begin
            st_new.hold = measured;
            st_new.age  = '0;
        end else if (age_inc > r_hold_reads) begin
            st_new.hold = (st_new.level > hd_dec) ? st_new.level : hd_dec;
            st_new.age  = age_inc;
        end else begin
            st_new.hold = st_cur.hold;
            st_new.age  = age_inc;
        end
        ch_last   = ((NW'(r_ch) + NW'(1)) == r_shown);
        slot_free = !r_out_v || o_out.ready;
        out_load  = slot_free && ((r_state == S_CALC) || (r_state == S_INV));
    end

    // memories
    assign wp_raddr = (r_state == S_IDLE) ? AW'(i_in.channel) : r_ch;

    always_ff @(posedge i_clk) begin
        r_wp_rd <= wp_mem[wp_raddr];
        if (r_s1_v) begin
            wp_mem[r_s1_ch] <= wp_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st_rd <= st_mem[r_ch];
        if ((r_state == S_CALC) && slot_free) begin
            st_mem[r_ch] <= st_new;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_thr    <= CLIP_THRESHOLD_RST;
            r_decay       <= DECAY_PER_READ_RST;
            r_hold_reads  <= HOLD_READS_RST;
            r_stale_reads <= STALE_READS_RST;
        end else if (cfg_fire) begin
            unique case (i_cfg.index)
                CFG_CLIP_THRESHOLD: begin
                    r_clip_thr <= i_cfg.data[LEVEL_W-1:0];
                end
                CFG_DECAY_PER_READ: begin
                    r_decay <= i_cfg.data[DECAY_W-1:0];
                end
                CFG_HOLD_READS: begin
                    r_hold_reads <= i_cfg.data[AGE_W-1:0];
                end
                CFG_STALE_READS: begin
                    r_stale_reads <= i_cfg.data[AGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sample stage payload
    always_ff @(posedge i_clk) begin
        r_s1_ch  <= AW'(i_in.channel);
        r_s1_mag <= mag;
        r_fw_ch  <= r_s1_ch;
        r_fw_val <= wp_new;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_wp_vld       <= '0;
            r_st_vld       <= '0;
            r_block_clip   <= 1'b0;
            r_clip_latched <= 1'b0;
            r_fresh_blk    <= 1'b0;
            r_reported     <= '0;
            r_shown        <= '0;
            r_live         <= 1'b0;
            r_stale_age    <= '0;
            r_ch           <= '0;
            r_rd_fresh     <= 1'b0;
            r_restart      <= 1'b0;
            r_s1_v         <= 1'b0;
            r_fw_v         <= 1'b0;
            r_out_v        <= 1'b0;
        end else begin
            r_s1_v <= in_fire && (i_in.op == OP_SAMPLE) && ch_ok;
            r_fw_v <= r_s1_v;
            if (r_s1_v) begin
                r_wp_vld[r_s1_ch] <= 1'b1;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (i_in.op)
                            OP_SAMPLE: begin
                                if (ch_ok && (mag >= r_clip_thr)) begin
                                    r_block_clip <= 1'b1;
                                end
                            end
                            OP_BLOCK_END: begin
                                for (int c = 0; c < MAX_CHANNELS; c++) begin
                                    if (c >= int'(cnt_sat)) begin
                                        r_wp_vld[c] <= 1'b0;
                                    end
                                end
                                if (r_block_clip) begin
                                    r_clip_latched <= 1'b1;
                                end
                                r_block_clip <= 1'b0;
                                r_reported   <= cnt_sat;
                                r_fresh_blk  <= 1'b1;
                            end
                            OP_READ: begin
                                if (i_in.source_running) begin
                                    if (r_fresh_blk) begin
                                        r_fresh_blk <= 1'b0;
                                        r_stale_age <= '0;
                                    end else begin
                                        r_stale_age <= stale_inc;
                                    end
                                end else begin
                                    r_fresh_blk <= 1'b0;
                                end
                                if (rd_invalid) begin
                                    r_live      <= 1'b0;
                                    r_shown     <= '0;
                                    r_wp_vld    <= '0;
                                    r_st_vld    <= '0;
                                    r_state     <= S_INV;
                                end else begin
                                    if (rd_restart) begin
                                        r_st_vld <= '0;
                                        r_shown  <= r_reported;
                                        r_live   <= 1'b1;
                                    end
                                    r_rd_fresh <= r_fresh_blk;
                                    r_restart  <= rd_restart;
                                    r_ch       <= '0;
                                    r_state    <= S_READ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (slot_free) begin
                        r_st_vld[r_ch] <= 1'b1;
                        if (r_rd_fresh) begin
                            r_wp_vld[r_ch] <= 1'b0;
                        end
                        r_out.reading_valid   <= 1'b1;
                        r_out.out_channel     <= CH_W'(r_ch);
                        r_out.peak_level      <= st_new.level;
                        r_out.hold_level      <= st_new.hold;
                        r_out.clipped         <= r_clip_latched;
                        r_out.last            <= ch_last;
                        if (ch_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + AW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_INV: begin
                    if (slot_free) begin
                        r_out   <= '{reading_valid: 1'b0, out_channel: '0,
                                     peak_level: '0, hold_level: '0,
                                     clipped: 1'b0, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.reading_valid = r_out.reading_valid;
    assign o_out.out_channel   = r_out.out_channel;
    assign o_out.peak_level    = r_out.peak_level;
    assign o_out.hold_level    = r_out.hold_level;
    assign o_out.clipped       = r_out.clipped;
    assign o_out.last          = r_out.last;

    // checks
    `APMH_ASSERT_NXT(a_read_leaves_idle, in_fire && (i_in.op == OP_READ), r_state != S_IDLE)
    `APMH_ASSERT_IMP(a_sample_stage_in_idle, r_s1_v, r_state == S_IDLE)
    `APMH_ASSERT_IMP(a_walk_in_range, r_state == S_CALC, NW'(r_ch) < r_shown)
    `APMH_ASSERT_IMP(a_invalid_is_last, r_out_v && !r_out.reading_valid, r_out.last)
    `APMH_ASSERT_IMP(a_busy_blocks_input, r_state != S_IDLE, !i_in.ready)

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the audio peak meter: a directed table of samples,
// block ends and reads, then random block sequences under several register
// settings, each result compared against an in-bench meter predictor or,
// for pinned directed rows, against the row's fixed expected result
module tb;
    import apmh_pkg::*;

    localparam int CHANNELS = 8;
    localparam int WAIT_MAX = 18;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam t_result NO_READING = '{reading_valid: 1'b0, out_channel: '0,
                                       peak_level: '0, hold_level: '0,
                                       clipped: 1'b0, last: 1'b1};

    typedef struct {
        logic [OP_W-1:0]            op;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CNT_W-1:0]           count;
        logic                       running;
        bit                         pinned;
        t_result                    want;
    } t_meter_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    apmh_in_if  meter_in();
    apmh_out_if meter_out();
    apmh_cfg_if meter_cfg();

    audio_peak_meter_with_hold_unit #(
        .MAX_CHANNELS(CHANNELS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (meter_cfg),
        .i_in   (meter_in),
        .o_out  (meter_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies
    logic [LEVEL_W-1:0] clip_thr;
    logic [DECAY_W-1:0] decay_q;
    logic [AGE_W-1:0]   hold_reads_q;
    logic [AGE_W-1:0]   stale_reads_q;

    // meter state
    logic [LEVEL_W-1:0] win_peak [CHANNELS];
    logic [LEVEL_W-1:0] lvl      [CHANNELS];
    logic [LEVEL_W-1:0] held     [CHANNELS];
    logic [AGE_W-1:0]   held_age [CHANNELS];
    bit                 blk_clip;
    bit                 clip_sticky;
    bit                 fresh;
    bit                 live;
    logic [CNT_W-1:0]   reported;
    logic [CNT_W-1:0]   shown;
    logic [AGE_W-1:0]   stale_cnt;

    t_result new_readings[$];
    t_result pending_readings[$];

    int mismatches = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    t_meter_item directed_rows [0:22] = '{
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b1, NO_READING},
        '{OP_SAMPLE,    3'd1, 26'sd1048575,   4'd0,  1'b0, 1'b0, '0},
        '{OP_SAMPLE,    3'd1, 26'h3FFFFFF,    4'd0,  1'b0, 1'b0, '0},
        '{OP_SAMPLE,    3'd3, -26'sd1048575,  4'd0,  1'b0, 1'b0, '0},
        '{OP_BLOCK_END, 3'd0, 26'sd0,         4'd4,  1'b0, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b0, '0},
        '{OP_SAMPLE,    3'd0, 26'sd33554431,  4'd0,  1'b0, 1'b0, '0},
        '{OP_SAMPLE,    3'd7, 26'h2000000,    4'd0,  1'b0, 1'b0, '0},
        '{OP_SAMPLE,    3'd2, 26'sd1048576,   4'd0,  1'b0, 1'b0, '0},
        '{OP_SAMPLE,    3'd5, 26'sd0,         4'd0,  1'b0, 1'b0, '0},
        '{OP_BLOCK_END, 3'd0, 26'sd0,         4'd15, 1'b0, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b0, '0},
        '{OP_UNUSED,    3'd6, 26'sd12345,     4'd3,  1'b1, 1'b0, '0},
        '{OP_SAMPLE,    3'd4, -26'sd20000000, 4'd0,  1'b0, 1'b0, '0},
        '{OP_BLOCK_END, 3'd0, 26'sd0,         4'd8,  1'b0, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b0, 1'b1, NO_READING},
        '{OP_BLOCK_END, 3'd0, 26'sd0,         4'd0,  1'b0, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b1, NO_READING},
        '{OP_BLOCK_END, 3'd0, 26'sd0,         4'd2,  1'b0, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b0, '0},
        '{OP_READ,      3'd0, 26'sd0,         4'd0,  1'b1, 1'b0, '0}
    };

    function automatic logic [LEVEL_W-1:0] decay_level(logic [LEVEL_W-1:0] x);
        logic [LEVEL_W+DECAY_W-1:0] prod;
        prod = x * decay_q;
        return prod[LEVEL_W+DECAY_W-1:DECAY_W];
    endfunction

    task automatic reset_meter();
        clip_thr      = CLIP_THRESHOLD_RST;
        decay_q       = DECAY_PER_READ_RST;
        hold_reads_q  = HOLD_READS_RST;
        stale_reads_q = STALE_READS_RST;
        for (int c = 0; c < CHANNELS; c++) begin
            win_peak[c] = '0;
            lvl[c]      = '0;
            held[c]     = '0;
            held_age[c] = '0;
        end
        blk_clip    = 1'b0;
        clip_sticky = 1'b0;
        fresh       = 1'b0;
        live        = 1'b0;
        reported    = '0;
        shown       = '0;
        stale_cnt   = '0;
    endtask

    task automatic forget_meter();
        live  = 1'b0;
        shown = '0;
        fresh = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            lvl[c]      = '0;
            held[c]     = '0;
            win_peak[c] = '0;
        end
    endtask

    task automatic advance_meter(input t_meter_item it);
        logic [SAMPLE_W:0]  mag;
        logic [LEVEL_W-1:0] measured;
        logic [LEVEL_W-1:0] lv;
        logic [LEVEL_W-1:0] hd;
        logic [CNT_W-1:0]   n;
        bit                 was_fresh;
        bit                 restart;
        t_result            res;
        new_readings.delete();
        unique case (it.op)
            OP_SAMPLE: begin
                mag = it.sample[SAMPLE_W-1] ? (27'h4000000 - {1'b0, it.sample})
                                            : {1'b0, it.sample};
                if (mag > {2'b00, FULL_SCALE}) mag = {2'b00, FULL_SCALE};
                if (mag[LEVEL_W-1:0] >= clip_thr) blk_clip = 1'b1;
                if (mag[LEVEL_W-1:0] > win_peak[it.channel]) begin
                    win_peak[it.channel] = mag[LEVEL_W-1:0];
                end
            end
            OP_BLOCK_END: begin
                n = (it.count > CHANNELS) ? CNT_W'(CHANNELS) : it.count;
                for (int c = int'(n); c < CHANNELS; c++) win_peak[c] = '0;
                if (blk_clip) clip_sticky = 1'b1;
                blk_clip = 1'b0;
                reported = n;
                fresh    = 1'b1;
            end
            OP_READ: begin
                if (!it.running) begin
                    forget_meter();
                    new_readings.push_back(NO_READING);
                    return;
                end
                was_fresh = fresh;
                if (fresh) begin
                    fresh     = 1'b0;
                    stale_cnt = '0;
                end else begin
                    if (stale_cnt < AGE_MAX) stale_cnt++;
                    if (!live || stale_cnt > stale_reads_q) begin
                        forget_meter();
                        new_readings.push_back(NO_READING);
                        return;
                    end
                end
                n = reported;
                if (n == 0) begin
                    forget_meter();
                    new_readings.push_back(NO_READING);
                    return;
                end
                restart = !live || (n != shown);
                if (restart) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        lvl[c]      = '0;
                        held[c]     = '0;
                        held_age[c] = '0;
                    end
                    shown = n;
                    live  = 1'b1;
                end
                for (int c = 0; c < int'(n); c++) begin
                    measured = '0;
                    if (was_fresh) begin
                        measured    = win_peak[c];
                        win_peak[c] = '0;
                    end
                    if (!restart && held_age[c] < AGE_MAX) held_age[c]++;
                    lv = restart ? lvl[c] : decay_level(lvl[c]);
                    if (measured > lv) lv = measured;
                    lvl[c] = lv;
                    if (measured >= held[c]) begin
                        held[c]     = measured;
                        held_age[c] = '0;
                    end else if (held_age[c] > hold_reads_q) begin
                        hd      = restart ? held[c] : decay_level(held[c]);
                        held[c] = (lv > hd) ? lv : hd;
                    end
                    res.reading_valid = 1'b1;
                    res.out_channel   = CH_W'(c);
                    res.peak_level    = lvl[c];
                    res.hold_level    = held[c];
                    res.clipped       = clip_sticky;
                    res.last          = (c + 1 == int'(n));
                    new_readings.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic int draw_wait(inout bit steady);
        if ($urandom_range(0, 24) == 0) steady = !steady;
        return steady ? 0 : int'($urandom_range(0, WAIT_MAX));
    endfunction

    function automatic t_meter_item random_item(logic [OP_W-1:0] op);
        t_meter_item it;
        it.op      = op;
        it.channel = CH_W'($urandom);
        it.sample  = SAMPLE_W'($urandom);
        it.count   = CNT_W'($urandom);
        it.running = 1'(($urandom));
        it.pinned  = 1'b0;
        it.want    = '0;
        return it;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int mag;
        logic [SAMPLE_W-1:0] corners [6] = '{26'h1FFFFFF, 26'h2000000, 26'h1000000,
                                             26'h3000000, 26'h0000000, 26'h2FFFFFF};
        case ($urandom_range(0, 4))
            0:       return SAMPLE_W'($urandom);
            1:       return corners[$urandom_range(0, 5)];
            2:       mag = int'(clip_thr) + int'($urandom_range(0, 8)) - 4;
            3:       mag = int'($urandom_range(0, 1 << 20));
            default: mag = int'($urandom_range(0, 1 << 24));
        endcase
        if (mag < 0) mag = 0;
        return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    task automatic send_item(input t_meter_item it);
        int gap;
        gap = draw_wait(send_steady);
        if (gap > 0) begin
            meter_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        meter_in.valid          <= 1'b1;
        meter_in.op             <= it.op;
        meter_in.channel        <= it.channel;
        meter_in.sample         <= it.sample;
        meter_in.channel_count  <= it.count;
        meter_in.source_running <= it.running;
        do @(posedge i_clk); while (!(meter_in.valid && meter_in.ready));
        advance_meter(it);
        if (it.pinned) pending_readings.push_back(it.want);
        else foreach (new_readings[k]) pending_readings.push_back(new_readings[k]);
        if (it.op != OP_UNUSED) items_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        meter_cfg.valid <= 1'b1;
        meter_cfg.index <= idx;
        meter_cfg.data  <= val;
        do @(posedge i_clk); while (!(meter_cfg.valid && meter_cfg.ready));
        unique case (idx)
            CFG_CLIP_THRESHOLD: clip_thr      = val[LEVEL_W-1:0];
            CFG_DECAY_PER_READ: decay_q       = val[DECAY_W-1:0];
            CFG_HOLD_READS:     hold_reads_q  = val[AGE_W-1:0];
            CFG_STALE_READS:    stale_reads_q = val[AGE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int clip, input int decay, input int hold,
                              input int stale);
        write_reg(CFG_CLIP_THRESHOLD, CFG_DATA_W'(clip));
        write_reg(CFG_DECAY_PER_READ, CFG_DATA_W'(decay));
        write_reg(CFG_HOLD_READS, CFG_DATA_W'(hold));
        write_reg(CFG_STALE_READS, CFG_DATA_W'(stale));
        meter_cfg.valid <= 1'b0;
    endtask

    task automatic drain_meter();
        meter_in.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly complete blocks with reads, some stale reads and stray items
    task automatic run_phase(input int budget);
        int target;
        int roll;
        logic [CNT_W-1:0] base;
        t_meter_item it;
        target = items_sent + budget;
        base   = CNT_W'($urandom_range(1, 9));
        while (items_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                repeat ($urandom_range(0, 5)) begin
                    it = random_item(OP_SAMPLE);
                    it.sample = pick_sample();
                    send_item(it);
                end
                it = random_item(OP_BLOCK_END);
                if ($urandom_range(0, 9) != 0) it.count = base;
                send_item(it);
                it = random_item(OP_READ);
                it.running = ($urandom_range(0, 9) != 0);
                send_item(it);
                repeat ($urandom_range(0, 2)) begin
                    it = random_item(OP_READ);
                    it.running = 1'b1;
                    send_item(it);
                end
            end else if (roll < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    it = random_item(OP_READ);
                    it.running = 1'b1;
                    send_item(it);
                end
            end else begin
                it = random_item(OP_W'($urandom_range(0, 3)));
                if (it.op == OP_SAMPLE) it.sample = pick_sample();
                send_item(it);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input t_result e, input t_result a);
        mismatches++;
        if (mismatches <= 10) begin
            $display("reading mismatch:%s", what);
            $display("  expected v=%0b ch=%0d pk=%h hd=%h clip=%0b last=%0b",
                     e.reading_valid, e.out_channel, e.peak_level, e.hold_level,
                     e.clipped, e.last);
            $display("  actual   v=%0b ch=%0d pk=%h hd=%h clip=%0b last=%0b",
                     a.reading_valid, a.out_channel, a.peak_level, a.hold_level,
                     a.clipped, a.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        string bad;
        if (i_rst_n && meter_out.valid && meter_out.ready) begin
            got.reading_valid = meter_out.reading_valid;
            got.out_channel   = meter_out.out_channel;
            got.peak_level    = meter_out.peak_level;
            got.hold_level    = meter_out.hold_level;
            got.clipped       = meter_out.clipped;
            got.last          = meter_out.last;
            if (pending_readings.size() == 0) begin
                report_mismatch(" none expected", '0, got);
            end else begin
                exp_r = pending_readings.pop_front();
                bad = "";
                if (got.reading_valid !== exp_r.reading_valid) bad = {bad, " reading_valid"};
                if (got.out_channel !== exp_r.out_channel) bad = {bad, " out_channel"};
                if (got.peak_level !== exp_r.peak_level) bad = {bad, " peak_level"};
                if (got.hold_level !== exp_r.hold_level) bad = {bad, " hold_level"};
                if (got.clipped !== exp_r.clipped) bad = {bad, " clipped"};
                if (got.last !== exp_r.last) bad = {bad, " last"};
                if (bad != "") report_mismatch(bad, exp_r, got);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((meter_in.valid && meter_in.ready) || (meter_out.valid && meter_out.ready) ||
            (meter_cfg.valid && meter_cfg.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int stall;
        meter_out.ready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!(meter_out.valid && meter_out.ready));
            stall = draw_wait(recv_steady);
            if (stall > 0) begin
                meter_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                meter_out.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n                 <= 1'b0;
        meter_in.valid          <= 1'b0;
        meter_in.op             <= OP_SAMPLE;
        meter_in.channel        <= '0;
        meter_in.sample         <= '0;
        meter_in.channel_count  <= '0;
        meter_in.source_running <= 1'b0;
        meter_cfg.valid         <= 1'b0;
        meter_cfg.index         <= CFG_CLIP_THRESHOLD;
        meter_cfg.data          <= '0;
        reset_meter();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) send_item(directed_rows[r]);
        drain_meter();

        set_config(0, 65535, 0, 1023);
        run_phase(50);
        drain_meter();

        set_config(int'(FULL_SCALE), 0, 1023, 0);
        run_phase(40);
        drain_meter();

        set_config($urandom_range(0, 16777216), $urandom_range(0, 65535),
                   $urandom_range(0, 3), $urandom_range(1, 5));
        run_phase(50);
        drain_meter();

        set_config(1 << 19, 50000, 2, 1023);
        run_phase(50);
        drain_meter();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
